// ----- rtl/core/fcrc_pkg.sv -----
// ----------------------------------------------------------------------------
// fcrc_pkg
// Shared types, constants and the byte table function of the frame CRC core.
// ----------------------------------------------------------------------------
package fcrc_pkg;

  // crc-32 generator, msb-first form
  localparam logic [31:0] CrcPoly   = 32'h04C1_1DB7;
  localparam logic [31:0] CrcTopBit = 32'h8000_0000;

  // byte count saturates once the register is primed
  localparam int unsigned CountWidth = 3;
  localparam logic [CountWidth-1:0] CountFull = 3'd4;

  typedef logic [CountWidth-1:0] count_t;

  // state of one frame in progress
  typedef struct packed {
    logic [31:0] crc;
    count_t      count;
  } crc_state_t;

  // update result handed from the datapath to the top level
  typedef struct packed {
    crc_state_t  next_state;
    logic [31:0] result;
  } crc_update_t;

  // augmented table entry for the old top byte
  function automatic logic [31:0] crc_table_entry(input logic [7:0] index);
    logic [31:0] v;
    v = {index, 24'h00_0000};
    for (int k = 0; k < 8; k++) begin
      if ((v & CrcTopBit) != 32'h0) begin
        v = {v[30:0], 1'b0} ^ CrcPoly;
      end else begin
        v = {v[30:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

// ----- rtl/core/fcrc_update.sv -----
// ----------------------------------------------------------------------------
// fcrc_update
// Single-byte CRC step: shifts a byte into the register and forms the
// frame result for the case where the byte closes the frame.
// ----------------------------------------------------------------------------
module fcrc_update (
  input  fcrc_pkg::crc_state_t  state_i,
  input  logic [7:0]            data_byte_i,
  output fcrc_pkg::crc_update_t update_o
);

  logic [31:0]      shifted;
  logic [31:0]      crc_next;
  logic [31:0]      result_word;
  fcrc_pkg::count_t count_next;

  // shift the new byte in at the bottom
  assign shifted = {state_i.crc[23:0], data_byte_i};

  // priming phase inverts after the fourth byte, then table updates
  always_comb begin
    if (state_i.count < fcrc_pkg::CountFull) begin
      count_next = state_i.count + fcrc_pkg::count_t'(1);
      if (count_next == fcrc_pkg::CountFull) begin
        crc_next = ~shifted;
      end else begin
        crc_next = shifted;
      end
    end else begin
      count_next = state_i.count;
      crc_next   = shifted ^ fcrc_pkg::crc_table_entry(state_i.crc[31:24]);
    end
  end

  // short frames come back packed little-endian, full frames inverted
  always_comb begin
    case (count_next)
      3'd1:    result_word = {24'h00_0000, crc_next[7:0]};
      3'd2:    result_word = {16'h0000, crc_next[7:0], crc_next[15:8]};
      3'd3:    result_word = {8'h00, crc_next[7:0], crc_next[15:8], crc_next[23:16]};
      default: result_word = ~crc_next;
    endcase
  end

  assign update_o.result           = result_word;
  assign update_o.next_state.crc   = crc_next;
  assign update_o.next_state.count = count_next;

endmodule

// ----- rtl/core/fcrc_out_reg.sv -----
// ----------------------------------------------------------------------------
// fcrc_out_reg
// Result register: holds one finished frame result word until it is taken.
// ----------------------------------------------------------------------------
module fcrc_out_reg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic [31:0] value_i,
  output logic        slot_free_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] crc_value_o
);

  logic        valid_q, valid_d;
  logic [31:0] value_q;

  // slot can take a new word when empty or when being drained now
  assign slot_free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, loaded only into a free slot
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      value_q <= value_i;
    end
  end

  assign out_valid_o = valid_q;
  assign crc_value_o = value_q;

endmodule

// ----- rtl/core/frame_crc32_stream_core.sv -----
// ----------------------------------------------------------------------------
// frame_crc32_stream_core
// Byte-serial CRC-32 (0x04C11DB7, msb-first) over frames with a last flag.
// ----------------------------------------------------------------------------
// One byte word is taken every clock cycle while no result is backed up. A
// byte is captured in the input register, the CRC step (shift plus one table
// entry) runs combinationally on the held byte, and on the last byte of a
// frame the result word passes from the input register into the result
// register, which presents it at the output once that register is free.
// Frames of one to three bytes return their bytes packed little-endian with
// zero fill instead of a CRC. Input stalls only while a last byte waits for
// a full result register to drain.
module frame_crc32_stream_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] crc_value_o
);

  logic                  in_valid_q, in_valid_d;
  logic [7:0]            byte_q;
  logic                  last_q;
  logic                  in_accept;
  logic                  advance;
  logic                  slot_free;
  fcrc_pkg::crc_state_t  state_q, state_d;
  fcrc_pkg::crc_update_t update;

  // held byte moves on unless it closes a frame and the result slot is busy
  assign advance    = in_valid_q && (!last_q || slot_free);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_valid_d = in_stall_o ? in_valid_q : in_valid_i;

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  fcrc_update u_update (
    .state_i     (state_q),
    .data_byte_i (byte_q),
    .update_o    (update)
  );

  // frame state, cleared after the last byte
  always_comb begin
    state_d = state_q;
    if (advance) begin
      if (last_q) begin
        state_d = '0;
      end else begin
        state_d = update.next_state;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  fcrc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && last_q),
    .value_i     (update.result),
    .slot_free_o (slot_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .crc_value_o (crc_value_o)
  );

`ifndef NO_ASSERTIONS
  // byte count never passes saturation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.count <= fcrc_pkg::CountFull)
    else $error("byte count beyond saturation");

  // a closing byte always produces a result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && last_q |=> out_valid_o)
    else $error("last byte without result");

  // state is cleared for the next frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && last_q |=> state_q.count == '0 && state_q.crc == 32'h0)
    else $error("frame state not cleared");

  // input stalls only behind a backed-up result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> last_q && out_valid_o && out_stall_i)
    else $error("input stalled without cause");
`endif

endmodule
